### design/bbcw_pkg.sv
// Package for the clipped-window box blur: sizes, register indexes, FSM states.
// No dependencies.
`default_nettype none
package bbcw_pkg;
  localparam int MAX_DIM_DEF      = 512;
  localparam int MAX_WINDOW_DEF   = 31;
  localparam int CHANNEL_BITS_DEF = 16;
  localparam int CFG_W            = 10;
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BLUR   = 2'd2;
  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_ACC, ST_DIV, ST_OUT
  } bbcw_state_t;
endpackage
`default_nettype wire

### design/box_blur_clipped_window_top.sv
// Box blur over a frame store held in one synchronous RAM.
// Depends on bbcw_pkg.
//
//  channel | ports                                  | direction
//  in      | in_valid/in_ready, kind,row,col,rgb    | into block
//  out     | out_valid/out_ready, out_red/green/blue| out of block
//  cfg     | cfg_we, cfg_index, cfg_data            | into block
//
// A write beat is taken in idle and leaves the block idle. A query reads its N
// window pixels (one a cycle through the registered RAM read port), adds the last
// read into the sum, runs a bit-serial divide of the 3 channels in parallel over
// the sum width and then loads the result into the output register; the next
// beat is taken only once the result is loaded and the block is idle again.
// An empty window goes straight to the result load, which gives zero.
// Reset is synchronous and clears control only; store contents are undefined.
// A finished result waits in the output register; the next beat is accepted
// meanwhile, and a query stalls only at its end if the result is still held.
`default_nettype none
module box_blur_clipped_window_top #(
  parameter int MAX_DIM      = bbcw_pkg::MAX_DIM_DEF,
  parameter int MAX_WINDOW   = bbcw_pkg::MAX_WINDOW_DEF,
  parameter int CHANNEL_BITS = bbcw_pkg::CHANNEL_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_kind,
  input  wire logic [8:0]  in_row,
  input  wire logic [8:0]  in_col,
  input  wire logic [15:0] in_in_red,
  input  wire logic [15:0] in_in_green,
  input  wire logic [15:0] in_in_blue,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_red,
  output logic [15:0]      out_green,
  output logic [15:0]      out_blue,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [bbcw_pkg::CFG_W-1:0] cfg_data
);
  import bbcw_pkg::*;

  localparam int AW  = $clog2(MAX_DIM);
  localparam int DW  = 3*CHANNEL_BITS;
  localparam int CNTW = $clog2(MAX_WINDOW*MAX_WINDOW+1);
  localparam int SW  = CHANNEL_BITS + CNTW;
  localparam int QW  = SW;
  localparam int CW  = $clog2(SW+1);
  localparam int BW  = $clog2(MAX_WINDOW+1);

  // configuration registers
  logic [CFG_W-1:0] width_r, height_r;
  logic [4:0]       blur_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(512);
      height_r <= CFG_W'(512);
      blur_r   <= 5'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        REG_BLUR:   blur_r   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // effective limits (13 bits covers MAX_DIM up to 4096)
  logic [12:0] w_eff, h_eff;
  logic [BW-1:0] bs_eff;
  logic [12:0] half;
  always_comb begin
    w_eff = (width_r == '0) ? 13'd1 : 13'(width_r);
    if (w_eff > 13'(MAX_DIM)) w_eff = 13'(MAX_DIM);
    h_eff = (height_r == '0) ? 13'd1 : 13'(height_r);
    if (h_eff > 13'(MAX_DIM)) h_eff = 13'(MAX_DIM);
    bs_eff = (32'(blur_r) > MAX_WINDOW) ? BW'(MAX_WINDOW) : BW'(blur_r);
    half = 13'(bs_eff >> 1);
  end

  // frame store
  logic [DW-1:0] mem [2**(2*AW)];
  logic          mem_we;
  logic [2*AW-1:0] wr_addr, rd_addr;
  logic [DW-1:0] rd_data_r;
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= {in_in_red[CHANNEL_BITS-1:0],
                                 in_in_green[CHANNEL_BITS-1:0],
                                 in_in_blue[CHANNEL_BITS-1:0]};
    rd_data_r <= mem[rd_addr];
  end

  bbcw_state_t state_r, state_nxt;
  logic [12:0] r1_r, c0_r, c1_r, r_r, c_r;
  logic [12:0] r1_nxt, c0_nxt, c1_nxt, r_nxt, c_nxt;
  logic        pend_r, pend_nxt;
  logic [SW-1:0] s0_r, s1_r, s2_r, s0_nxt, s1_nxt, s2_nxt;
  logic [CNTW-1:0] n_r, n_nxt;
  logic [CW-1:0]   it_r, it_nxt;
  logic [QW-1:0]   q0_r, q1_r, q2_r, q0_nxt, q1_nxt, q2_nxt;
  logic [CNTW:0]   m0_r, m1_r, m2_r, m0_nxt, m1_nxt, m2_nxt;
  logic            ov_r, ov_nxt;
  logic [15:0]     or_r, og_r, ob_r, or_nxt, og_nxt, ob_nxt;

  // window clipping of a query beat
  logic [12:0] ra, rb, ca, cb;
  logic        empty;
  always_comb begin
    ra = (13'(in_row) >= half) ? 13'(in_row) - half : 13'd0;
    rb = 13'(in_row) + half;
    if (rb > h_eff - 13'd1) rb = h_eff - 13'd1;
    ca = (13'(in_col) >= half) ? 13'(in_col) - half : 13'd0;
    cb = 13'(in_col) + half;
    if (cb > w_eff - 13'd1) cb = w_eff - 13'd1;
    empty = (ra > rb) || (ca > cb);
  end

  // one restoring step per channel
  function automatic logic [CNTW:0] rem_step(input logic [CNTW:0] m, input logic b,
                                             input logic [CNTW-1:0] d);
    logic [CNTW+1:0] t;
    t = {m, b};
    if (t >= {2'b0, d}) t = t - {2'b0, d};
    return t[CNTW:0];
  endfunction
  function automatic logic q_bit(input logic [CNTW:0] m, input logic b,
                                 input logic [CNTW-1:0] d);
    return {m, b} >= {2'b0, d};
  endfunction

  always_comb begin
    state_nxt = state_r;
    r1_nxt = r1_r; c0_nxt = c0_r; c1_nxt = c1_r;
    r_nxt = r_r; c_nxt = c_r; pend_nxt = 1'b0;
    s0_nxt = s0_r; s1_nxt = s1_r; s2_nxt = s2_r; n_nxt = n_r;
    it_nxt = it_r; q0_nxt = q0_r; q1_nxt = q1_r; q2_nxt = q2_r;
    m0_nxt = m0_r; m1_nxt = m1_r; m2_nxt = m2_r;
    ov_nxt = ov_r; or_nxt = or_r; og_nxt = og_r; ob_nxt = ob_r;
    mem_we = 1'b0;
    wr_addr = {AW'(in_row), AW'(in_col)};
    rd_addr = {AW'(r_r), AW'(c_r)};
    in_ready = 1'b0;
    if (out_valid && out_ready) ov_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!in_kind) begin
            mem_we = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
          end else begin
            s0_nxt = '0; s1_nxt = '0; s2_nxt = '0; n_nxt = '0;
            r1_nxt = rb; c0_nxt = ca; c1_nxt = cb;
            r_nxt = ra; c_nxt = ca;
            state_nxt = empty ? ST_OUT : ST_READ;
          end
        end
      end
      ST_READ: begin
        // issue a read, accumulate the previous one
        pend_nxt = 1'b1;
        if (pend_r) begin
          s0_nxt = s0_r + SW'(rd_data_r[DW-1 -: CHANNEL_BITS]);
          s1_nxt = s1_r + SW'(rd_data_r[2*CHANNEL_BITS-1 -: CHANNEL_BITS]);
          s2_nxt = s2_r + SW'(rd_data_r[CHANNEL_BITS-1:0]);
          n_nxt  = n_r + CNTW'(1);
        end
        if (c_r == c1_r) begin
          c_nxt = c0_r;
          r_nxt = r_r + 13'd1;
          if (r_r == r1_r) state_nxt = ST_ACC;
        end else begin
          c_nxt = c_r + 13'd1;
        end
      end
      ST_ACC: begin
        s0_nxt = s0_r + SW'(rd_data_r[DW-1 -: CHANNEL_BITS]);
        s1_nxt = s1_r + SW'(rd_data_r[2*CHANNEL_BITS-1 -: CHANNEL_BITS]);
        s2_nxt = s2_r + SW'(rd_data_r[CHANNEL_BITS-1:0]);
        n_nxt  = n_r + CNTW'(1);
        it_nxt = CW'(SW);
        m0_nxt = '0; m1_nxt = '0; m2_nxt = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // bit-serial restoring divide, MSB first
        q0_nxt = {q0_r[QW-2:0], q_bit(m0_r, s0_r[SW-1], n_r)};
        q1_nxt = {q1_r[QW-2:0], q_bit(m1_r, s1_r[SW-1], n_r)};
        q2_nxt = {q2_r[QW-2:0], q_bit(m2_r, s2_r[SW-1], n_r)};
        m0_nxt = rem_step(m0_r, s0_r[SW-1], n_r);
        m1_nxt = rem_step(m1_r, s1_r[SW-1], n_r);
        m2_nxt = rem_step(m2_r, s2_r[SW-1], n_r);
        s0_nxt = s0_r << 1; s1_nxt = s1_r << 1; s2_nxt = s2_r << 1;
        it_nxt = it_r - CW'(1);
        if (it_r == CW'(1)) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          or_nxt = (n_r == '0) ? 16'd0 : 16'(q0_r);
          og_nxt = (n_r == '0) ? 16'd0 : 16'(q1_r);
          ob_nxt = (n_r == '0) ? 16'd0 : 16'(q2_r);
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r1_r <= r1_nxt; c0_r <= c0_nxt; c1_r <= c1_nxt;
    r_r <= r_nxt; c_r <= c_nxt;
    s0_r <= s0_nxt; s1_r <= s1_nxt; s2_r <= s2_nxt; n_r <= n_nxt;
    it_r <= it_nxt; q0_r <= q0_nxt; q1_r <= q1_nxt; q2_r <= q2_nxt;
    m0_r <= m0_nxt; m1_r <= m1_nxt; m2_r <= m2_nxt;
    or_r <= or_nxt; og_r <= og_nxt; ob_r <= ob_nxt;
  end

  assign out_valid = ov_r;
  assign out_red   = or_r;
  assign out_green = og_r;
  assign out_blue  = ob_r;
endmodule
`default_nettype wire

### design/bbcw_checker.sv
// Port-level checker for the box blur top level, bound to it below.
// Imports bbcw_pkg, though it uses none of its items.
`default_nettype none
module bbcw_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_kind,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [15:0] out_red
);
  import bbcw_pkg::*;
  // a held result stays valid and keeps its red value
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red)) else $error("result dropped");
  // a query beat blocks the input next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind |=> !in_ready) else $error("query not held busy");
  // a write beat leaves the block ready
  a_wr: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_kind |=> in_ready) else $error("write stalled");
  // no result out of reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid) else $error("valid in reset");
endmodule
bind box_blur_clipped_window_top bbcw_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_kind(in_kind), .out_valid(out_valid), .out_ready(out_ready), .out_red(out_red));
`default_nettype wire
